// ===== sv/bdhr_pkg.sv =====
// ----------------------------------------------------------------------------
// bdhr_pkg: shared types and constants of the button debounce / hold / repeat
// speed-set unit.
// ----------------------------------------------------------------------------
package bdhr_pkg;

  // Field widths
  localparam int TIME_W  = 32;
  localparam int MS_W    = 16;
  localparam int POWER_W = 7;
  localparam int RPM_W   = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_MS   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_MS       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT_MS     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CONTROL_MODE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INITIAL_POWER = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INITIAL_RPM   = 3'd5;

  // Register defaults
  localparam logic [MS_W-1:0]    DEBOUNCE_RST = 16'd50;
  localparam logic [MS_W-1:0]    HOLD_RST     = 16'd500;
  localparam logic [MS_W-1:0]    REPEAT_RST   = 16'd100;
  localparam logic [POWER_W-1:0] INIT_POWER_RST = 7'd0;
  localparam logic [RPM_W-1:0]   INIT_RPM_RST   = 16'd0;

  // Control modes
  localparam logic MODE_POWER = 1'b0;
  localparam logic MODE_SPEED = 1'b1;

  // Target stepping
  localparam logic [POWER_W-1:0] POWER_MAX     = 7'd100;
  localparam logic [RPM_W-1:0]   RPM_INCREMENT = 16'd100;
  localparam logic [RPM_W-1:0]   RPM_MAX       = 16'hFFFF;

  // Pin levels (active low buttons)
  localparam logic LEVEL_PRESSED  = 1'b0;
  localparam logic LEVEL_RELEASED = 1'b1;

  // Timing settings shared by all button lanes
  typedef struct packed {
    logic [MS_W-1:0] debounce_ms;
    logic [MS_W-1:0] hold_ms;
    logic [MS_W-1:0] repeat_ms;
  } bdhr_timing_t;

  // Per-tick button events from the lanes
  typedef struct packed {
    logic start_stop;
    logic up;
    logic down;
  } bdhr_events_t;

  // One result word
  typedef struct packed {
    logic               start_event;
    logic               stop_event;
    logic               motor_running;
    logic [POWER_W-1:0] target_power;
    logic [RPM_W-1:0]   target_rpm;
  } bdhr_result_t;

  // Clamp a power value to the legal range
  function automatic logic [POWER_W-1:0] clamp_power(input logic [POWER_W-1:0] v);
    return (v > POWER_MAX) ? POWER_MAX : v;
  endfunction

endpackage

// ===== sv/bdhr_in_if.sv =====
// ----------------------------------------------------------------------------
// bdhr_in_if: tick channel, time stamp plus three button pin levels.
// ----------------------------------------------------------------------------
interface bdhr_in_if;
  import bdhr_pkg::*;

  logic              valid;
  logic              ready;
  logic [TIME_W-1:0] now_ms;
  logic              level_start_stop;
  logic              level_up;
  logic              level_down;

  modport source (output valid, now_ms, level_start_stop, level_up, level_down,
                  input ready);
  modport sink   (input valid, now_ms, level_start_stop, level_up, level_down,
                  output ready);
endinterface

// ===== sv/bdhr_out_if.sv =====
// ----------------------------------------------------------------------------
// bdhr_out_if: result channel, events and current targets after each tick.
// ----------------------------------------------------------------------------
interface bdhr_out_if;
  import bdhr_pkg::*;

  logic               valid;
  logic               ready;
  logic               start_event;
  logic               stop_event;
  logic               motor_running;
  logic [POWER_W-1:0] target_power;
  logic [RPM_W-1:0]   target_rpm;

  modport source (output valid, start_event, stop_event, motor_running,
                  target_power, target_rpm, input ready);
  modport sink   (input valid, start_event, stop_event, motor_running,
                  target_power, target_rpm, output ready);
endinterface

// ===== sv/bdhr_cfg_if.sv =====
// ----------------------------------------------------------------------------
// bdhr_cfg_if: configuration write channel, register index and write data.
// ----------------------------------------------------------------------------
interface bdhr_cfg_if;
  import bdhr_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== sv/bdhr_lane.sv =====
// ----------------------------------------------------------------------------
// bdhr_lane: one button lane. Debounce, hold detection and auto-repeat with
// wrapping 32-bit elapsed-time compares; flags one event per tick at most.
// ----------------------------------------------------------------------------
module bdhr_lane (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         advance,
  input  logic [bdhr_pkg::TIME_W-1:0]  now_ms,
  input  logic                         level,
  input  bdhr_pkg::bdhr_timing_t       timing,
  output logic                         event_hit
);
  import bdhr_pkg::*;

  logic              last_level_r, last_level_nxt;
  logic              pressed_r, pressed_nxt;
  logic              held_r, held_nxt;
  logic [TIME_W-1:0] press_time_r, press_time_nxt;
  logic [TIME_W-1:0] repeat_time_r, repeat_time_nxt;

  logic [TIME_W-1:0] since_press;
  logic [TIME_W-1:0] since_repeat;
  logic              fall, rise;
  logic              debounce_ok, hold_ok, repeat_ok;

  // Elapsed times, wrapping
  assign since_press  = now_ms - press_time_r;
  assign since_repeat = now_ms - repeat_time_r;
  assign debounce_ok  = since_press  > {{(TIME_W-MS_W){1'b0}}, timing.debounce_ms};
  assign hold_ok      = since_press  > {{(TIME_W-MS_W){1'b0}}, timing.hold_ms};
  assign repeat_ok    = since_repeat > {{(TIME_W-MS_W){1'b0}}, timing.repeat_ms};

  assign fall = (level == LEVEL_PRESSED)  && (last_level_r == LEVEL_RELEASED);
  assign rise = (level == LEVEL_RELEASED) && (last_level_r == LEVEL_PRESSED);

  // Next state and event
  always_comb begin
    last_level_nxt  = level;
    pressed_nxt     = pressed_r;
    held_nxt        = held_r;
    press_time_nxt  = press_time_r;
    repeat_time_nxt = repeat_time_r;
    event_hit       = 1'b0;
    priority if (fall) begin
      if (debounce_ok) begin
        pressed_nxt     = 1'b1;
        press_time_nxt  = now_ms;
        repeat_time_nxt = now_ms;
        event_hit       = 1'b1;
      end
    end else if (rise) begin
      pressed_nxt = 1'b0;
      held_nxt    = 1'b0;
    end else if (pressed_r && (level == LEVEL_PRESSED)) begin
      if (!held_r && hold_ok) begin
        held_nxt        = 1'b1;
        repeat_time_nxt = now_ms;
        event_hit       = 1'b1;
      end else if (held_r && repeat_ok) begin
        repeat_time_nxt = now_ms;
        event_hit       = 1'b1;
      end
    end else begin
      // steady level with no press pending: state holds
    end
  end

  // Lane state, updated per accepted tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_level_r  <= LEVEL_RELEASED;
      pressed_r     <= 1'b0;
      held_r        <= 1'b0;
      press_time_r  <= '0;
      repeat_time_r <= '0;
    end else if (advance) begin
      last_level_r  <= last_level_nxt;
      pressed_r     <= pressed_nxt;
      held_r        <= held_nxt;
      press_time_r  <= press_time_nxt;
      repeat_time_r <= repeat_time_nxt;
    end
  end

endmodule

// ===== sv/bdhr_merge.sv =====
// ----------------------------------------------------------------------------
// bdhr_merge: combines the lane events. Start/stop toggles the run flag; up
// and down step the power or rpm target in that order, each clamped.
// ----------------------------------------------------------------------------
module bdhr_merge (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          advance,
  input  bdhr_pkg::bdhr_events_t        events,
  input  logic                          mode,
  input  logic                          load_power,
  input  logic                          load_rpm,
  input  logic [bdhr_pkg::CFG_DATA_W-1:0] load_data,
  output bdhr_pkg::bdhr_result_t        result
);
  import bdhr_pkg::*;

  logic               run_r, run_nxt;
  logic [POWER_W-1:0] power_r, power_nxt, power_up;
  logic [RPM_W-1:0]   rpm_r, rpm_nxt, rpm_up;
  logic [RPM_W:0]     rpm_sum;

  // Run flag toggle
  assign run_nxt = events.start_stop ? !run_r : run_r;

  // Power: up then down
  always_comb begin
    power_up = power_r;
    if (events.up) begin
      power_up = (power_r >= POWER_MAX) ? POWER_MAX : power_r + 7'd1;
    end
    power_nxt = power_up;
    if (events.down && (power_up != '0)) begin
      power_nxt = power_up - 7'd1;
    end
  end

  // Rpm: up saturates, down floors at zero
  assign rpm_sum = {1'b0, rpm_r} + {1'b0, RPM_INCREMENT};
  always_comb begin
    rpm_up = rpm_r;
    if (events.up) begin
      rpm_up = rpm_sum[RPM_W] ? RPM_MAX : rpm_sum[RPM_W-1:0];
    end
    rpm_nxt = rpm_up;
    if (events.down) begin
      rpm_nxt = (rpm_up > RPM_INCREMENT) ? rpm_up - RPM_INCREMENT : '0;
    end
  end

  // Result word after this tick
  always_comb begin
    result.start_event   = events.start_stop && !run_r;
    result.stop_event    = events.start_stop && run_r;
    result.motor_running = run_nxt;
    result.target_power  = (mode == MODE_POWER) ? power_nxt : power_r;
    result.target_rpm    = (mode == MODE_SPEED) ? rpm_nxt : rpm_r;
  end

  // Held state; register writes reload the targets
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r   <= 1'b0;
      power_r <= clamp_power(INIT_POWER_RST);
      rpm_r   <= INIT_RPM_RST;
    end else begin
      if (advance) begin
        run_r   <= result.motor_running;
        power_r <= result.target_power;
        rpm_r   <= result.target_rpm;
      end
      if (load_power) begin
        power_r <= clamp_power(load_data[POWER_W-1:0]);
      end
      if (load_rpm) begin
        rpm_r <= load_data[RPM_W-1:0];
      end
    end
  end

endmodule

// ===== sv/button_debounce_hold_repeat_speed_set_unit.sv =====
// The three button lanes and merge step form a result word in the accepting
// cycle, held in the output register or, while that waits, in the skid word.
// One tick per cycle while the skid word is empty; a two-word output buffer
// keeps input open while a result waits. Reset (synchronous, rst_n low) clears
// all button state and the run flag, loads register defaults and zero targets.
// ----------------------------------------------------------------------------
// button_debounce_hold_repeat_speed_set_unit: top level
// Three parallel button lanes, an event merge with run and target state, the
// configuration registers and a skid-buffered result output.
// ----------------------------------------------------------------------------
module button_debounce_hold_repeat_speed_set_unit (
  input  logic       clk,
  input  logic       rst_n,
  bdhr_in_if.sink    in_ch,
  bdhr_out_if.source out_ch,
  bdhr_cfg_if.sink   cfg_ch
);
  import bdhr_pkg::*;

  // Configuration registers
  bdhr_timing_t timing_r;
  logic         mode_r;
  logic         cfg_wr;
  logic         load_power, load_rpm;

  // Datapath
  logic         in_acc;
  bdhr_events_t events;
  bdhr_result_t result;

  // Output buffer
  logic         out_valid_r;
  bdhr_result_t out_res_r;
  logic         skid_valid_r;
  bdhr_result_t skid_res_r;
  logic         out_free;

  // Configuration write port
  assign cfg_ch.ready = 1'b1;
  assign cfg_wr       = cfg_ch.valid && cfg_ch.ready;
  assign load_power   = cfg_wr && (cfg_ch.index == REG_INITIAL_POWER);
  assign load_rpm     = cfg_wr && (cfg_ch.index == REG_INITIAL_RPM);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timing_r.debounce_ms <= DEBOUNCE_RST;
      timing_r.hold_ms     <= HOLD_RST;
      timing_r.repeat_ms   <= REPEAT_RST;
      mode_r               <= MODE_POWER;
    end else if (cfg_wr) begin
      unique case (cfg_ch.index)
        REG_DEBOUNCE_MS:  timing_r.debounce_ms <= cfg_ch.data[MS_W-1:0];
        REG_HOLD_MS:      timing_r.hold_ms     <= cfg_ch.data[MS_W-1:0];
        REG_REPEAT_MS:    timing_r.repeat_ms   <= cfg_ch.data[MS_W-1:0];
        REG_CONTROL_MODE: mode_r               <= cfg_ch.data[0];
        default: ;
      endcase
    end
  end

  // Input handshake
  assign in_ch.ready = !skid_valid_r;
  assign in_acc      = in_ch.valid && in_ch.ready;

  // Button lanes
  bdhr_lane u_lane_start_stop (
    .clk       (clk),
    .rst_n     (rst_n),
    .advance   (in_acc),
    .now_ms    (in_ch.now_ms),
    .level     (in_ch.level_start_stop),
    .timing    (timing_r),
    .event_hit (events.start_stop)
  );

  bdhr_lane u_lane_up (
    .clk       (clk),
    .rst_n     (rst_n),
    .advance   (in_acc),
    .now_ms    (in_ch.now_ms),
    .level     (in_ch.level_up),
    .timing    (timing_r),
    .event_hit (events.up)
  );

  bdhr_lane u_lane_down (
    .clk       (clk),
    .rst_n     (rst_n),
    .advance   (in_acc),
    .now_ms    (in_ch.now_ms),
    .level     (in_ch.level_down),
    .timing    (timing_r),
    .event_hit (events.down)
  );

  // Event merge
  bdhr_merge u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .advance    (in_acc),
    .events     (events),
    .mode       (mode_r),
    .load_power (load_power),
    .load_rpm   (load_rpm),
    .load_data  (cfg_ch.data),
    .result     (result)
  );

  // Output register plus skid word
  assign out_free = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r  <= skid_valid_r || in_acc;
      skid_valid_r <= 1'b0;
    end else if (in_acc) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_res_r <= skid_valid_r ? skid_res_r : result;
    end else if (in_acc) begin
      skid_res_r <= result;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.start_event   = out_res_r.start_event;
  assign out_ch.stop_event    = out_res_r.stop_event;
  assign out_ch.motor_running = out_res_r.motor_running;
  assign out_ch.target_power  = out_res_r.target_power;
  assign out_ch.target_rpm    = out_res_r.target_rpm;

`ifndef SYNTHESIS
  // Skid word only fills behind a waiting output word
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid word valid while output register empty");

  // Start and stop never in the same word
  a_start_stop_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_res_r.start_event && out_res_r.stop_event))
    else $error("start and stop event in one word");

  // Run flag agrees with the event that changed it
  a_run_matches_event: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_res_r.start_event || out_res_r.stop_event)) |->
      (out_res_r.motor_running == out_res_r.start_event))
    else $error("motor_running disagrees with start/stop event");

  // Power target stays in range
  a_power_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_res_r.target_power <= POWER_MAX))
    else $error("target power above maximum");
`endif

endmodule
